// ===== rtl/core/cmtd_pkg.sv =====
// Package for the cone map block: status codes, controller states, CORDIC
// arctangent table and the command/status structs between controller and datapath.
// No dependencies.
package cmtd_pkg;

  localparam logic [2:0] ST_POSE   = 3'd0;
  localparam logic [2:0] ST_ADDED  = 3'd1;
  localparam logic [2:0] ST_DUP    = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_NOPOSE = 3'd4;

  localparam int CordicSteps = 24;
  localparam logic signed [33:0] CordicOne = 34'sd652032874;
  localparam logic [20:0] RadiusReset = 21'd196608;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORDIC,
    S_ROT,
    S_SCAN,
    S_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic pose_wr;    // store a pose
    logic cordic_init;
    logic cordic_step;
    logic rot_step;   // one of the rotation phases
    logic scan_init;
    logic scan_step;
    logic commit;     // finish the item into the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_pose;    // the offered item is a pose
    logic held_pose;  // the captured item is a pose
    logic pose_valid;
    logic cordic_done;
    logic rot_done;
    logic scan_done;
  } sts_t;

  function automatic logic [31:0] atan_lookup(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/cmtd_ctrl.sv =====
// Controller for the cone map block: sequences capture, CORDIC, rotation,
// table scan and result hand-off. Depends on cmtd_pkg.
module cmtd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           out_free,
  input  cmtd_pkg::sts_t sts,
  output logic           busy,
  output cmtd_pkg::cmd_t cmd
);
  import cmtd_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_DONE;
          if (!sts.is_pose && sts.pose_valid) begin
            cmd.cordic_init = 1'b1;
            state_next = S_CORDIC;
          end
        end
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (sts.cordic_done) state_next = S_ROT;
      end
      S_ROT: begin
        cmd.rot_step = 1'b1;
        if (sts.rot_done) begin
          cmd.scan_init = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          cmd.pose_wr = sts.held_pose;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/cmtd_dp.sv =====
// Datapath for the cone map block: pose registers, CORDIC, rotation
// multiplier, cone tables with a one-entry-per-cycle scan. Depends on cmtd_pkg.
module cmtd_dp #(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  cmtd_pkg::cmd_t     cmd,
  output cmtd_pkg::sts_t     sts,
  input  logic [20:0]        dup_radius,
  input  logic               in_req_type,
  input  logic signed [31:0] in_pose_x,
  input  logic signed [31:0] in_pose_y,
  input  logic [15:0]        in_pose_heading,
  input  logic signed [23:0] in_cone_x,
  input  logic signed [23:0] in_cone_y,
  input  logic signed [23:0] in_cone_z,
  input  logic               in_cone_color,
  output logic [2:0]         res_status,
  output logic signed [31:0] res_global_x,
  output logic signed [31:0] res_global_y,
  output logic [7:0]         res_slot,
  output logic [8:0]         res_color_count
);
  import cmtd_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = AW + 1;
  localparam int Depth = 2 ** MW;

  // Pose state.
  logic signed [31:0] veh_x, veh_y;
  logic [15:0]        veh_heading;
  logic               pose_valid;
  logic [CW-1:0]      blue_count, yellow_count;

  // Captured item.
  logic               req_type, color;
  logic signed [31:0] pend_x, pend_y;
  logic [15:0]        pend_heading;
  logic signed [23:0] cone_x, cone_y, cone_z;

  // CORDIC.
  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic [4:0]         citer;
  logic               flip;
  logic [31:0]        ang;
  logic               fold;
  logic [31:0]        ang_fold;
  logic               cordic_done;

  // Rotation.
  logic [2:0]         rphase;
  logic signed [33:0] cos_v, sin_v;
  logic signed [57:0] prod;
  logic signed [59:0] acc_x, acc_y;
  logic signed [31:0] gx, gy;

  // Scan.
  logic [CW-1:0]      idx;
  logic [CW-1:0]      cnt;
  logic               rd_valid;
  logic [AW-1:0]      rd_slot;
  logic               dup;
  logic [AW-1:0]      dup_slot;
  logic signed [31:0] rd_x, rd_y;
  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  logic [41:0]        r2;
  logic [43:0]        d2;
  logic               near;

  // Tables.
  logic [31:0] mem_x [Depth];
  logic [31:0] mem_y [Depth];
  logic [23:0] mem_z [Depth];

  assign cnt = color ? yellow_count : blue_count;
  assign ang = {pend_heading, 16'd0};

  // Angles in the second and third quadrant are turned by half a turn.
  assign fold = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
  assign ang_fold = fold ? ang - 32'h8000_0000 : ang;

  // Capture and pose registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type     <= in_req_type;
      color        <= in_cone_color;
      pend_x       <= in_pose_x;
      pend_y       <= in_pose_y;
      pend_heading <= in_req_type ? veh_heading : in_pose_heading;
      cone_x       <= in_cone_x;
      cone_y       <= in_cone_y;
      cone_z       <= in_cone_z;
    end
    if (rst) begin
      veh_x <= '0; veh_y <= '0; veh_heading <= '0; pose_valid <= 1'b0;
    end else if (cmd.pose_wr) begin
      veh_x <= pend_x; veh_y <= pend_y; veh_heading <= pend_heading;
      pose_valid <= 1'b1;
    end
  end

  // Step counter: code 31 stands for step 0 after the fold cycle.
  function automatic logic [4:0] citer_i();
    return (citer == 5'd31) ? 5'd0 : citer;
  endfunction

  // CORDIC, one micro-rotation per cycle.
  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      cx <= CordicOne;
      cy <= '0;
      citer <= '0;
      cordic_done <= 1'b0;
    end else if (cmd.cordic_step && !cordic_done) begin
      if (citer == 5'd0) begin
        // First step resolves the quadrant fold.
        flip <= fold;
        cz <= $signed({ang_fold[31], ang_fold});
        citer <= 5'd31;
      end else begin
        if (!cz[32]) begin
          cx <= cx - (cy >>> citer_i());
          cy <= cy + (cx >>> citer_i());
          cz <= cz - $signed({1'b0, atan_lookup(citer_i())});
        end else begin
          cx <= cx + (cy >>> citer_i());
          cy <= cy - (cx >>> citer_i());
          cz <= cz + $signed({1'b0, atan_lookup(citer_i())});
        end
        citer <= (citer == 5'd31) ? 5'd1 : citer + 5'd1;
        if (citer_i() == 5'(CordicSteps - 1)) cordic_done <= 1'b1;
      end
    end
  end

  assign cos_v = flip ? -cx : cx;
  assign sin_v = flip ? -cy : cy;

  // Rotation: four products through one multiplier, registered.
  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      rphase <= '0;
      acc_x <= '0;
      acc_y <= '0;
    end else if (cmd.rot_step) begin
      rphase <= rphase + 3'd1;
      case (rphase)
        3'd0: prod <= cone_x * cos_v;
        3'd1: begin acc_x <= acc_x + prod; prod <= cone_y * sin_v; end
        3'd2: begin acc_x <= acc_x - prod; prod <= cone_x * sin_v; end
        3'd3: begin acc_y <= acc_y + prod; prod <= cone_y * cos_v; end
        3'd4: begin
          acc_y <= acc_y + prod;
        end
        3'd5: begin
          gx <= veh_x + 32'((acc_x + 60'sd536870912) >>> 30);
          gy <= veh_y + 32'((acc_y + 60'sd536870912) >>> 30);
        end
        default: ;
      endcase
    end
  end

  assign sts.rot_done = cmd.rot_step && (rphase == 3'd5);
  assign sts.cordic_done = cordic_done;

  // Scan: read one entry a cycle, test the previous one.
  assign dx  = {rd_x[31], rd_x} - {gx[31], gx};
  assign dy  = {rd_y[31], rd_y} - {gy[31], gy};
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  assign r2  = 42'(dup_radius) * 42'(dup_radius);
  assign d2  = 44'(adx[20:0] * adx[20:0]) + 44'(ady[20:0] * ady[20:0]);
  assign near = (adx < 33'(dup_radius)) && (ady < 33'(dup_radius))
                && (d2 < 44'(r2));

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      idx <= '0;
      rd_valid <= 1'b0;
      dup <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_x <= mem_x[{color, idx[AW-1:0]}];
      rd_y <= mem_y[{color, idx[AW-1:0]}];
      rd_slot <= idx[AW-1:0];
      rd_valid <= (idx < cnt) && !dup && !(rd_valid && near);
      if (idx < cnt) idx <= idx + 1'b1;
      if (rd_valid && near && !dup) begin
        dup <= 1'b1;
        dup_slot <= rd_slot;
      end
    end
  end

  assign sts.scan_done = cmd.scan_step && !rd_valid && (dup || idx == cnt);

  // Commit: table write, counts and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      blue_count <= '0;
      yellow_count <= '0;
    end else if (cmd.commit && req_type && pose_valid && !dup
                 && cnt < CW'(CAPACITY)) begin
      if (color) yellow_count <= yellow_count + 1'b1;
      else       blue_count <= blue_count + 1'b1;
    end
    if (cmd.commit && req_type && pose_valid && !dup && cnt < CW'(CAPACITY)) begin
      mem_x[{color, cnt[AW-1:0]}] <= gx;
      mem_y[{color, cnt[AW-1:0]}] <= gy;
      mem_z[{color, cnt[AW-1:0]}] <= cone_z;
    end
    if (cmd.commit) begin
      if (!req_type) begin
        res_status <= ST_POSE;
        res_global_x <= '0;
        res_global_y <= '0;
        res_slot <= '0;
        res_color_count <= '0;
      end else if (!pose_valid) begin
        res_status <= ST_NOPOSE;
        res_global_x <= '0;
        res_global_y <= '0;
        res_slot <= '0;
        res_color_count <= 9'(cnt);
      end else begin
        res_global_x <= gx;
        res_global_y <= gy;
        if (dup) begin
          res_status <= ST_DUP;
          res_slot <= 8'(dup_slot);
          res_color_count <= 9'(cnt);
        end else if (cnt >= CW'(CAPACITY)) begin
          res_status <= ST_FULL;
          res_slot <= '0;
          res_color_count <= 9'(cnt);
        end else begin
          res_status <= ST_ADDED;
          res_slot <= 8'(cnt);
          res_color_count <= 9'(cnt + 1'b1);
        end
      end
    end
  end

  assign sts.is_pose = !in_req_type;
  assign sts.held_pose = !req_type;
  assign sts.pose_valid = pose_valid;

endmodule

// ===== rtl/core/cone_map_transform_dedup.sv =====
// Top level of the cone map block: stream ports, configuration register,
// output register. Depends on cmtd_pkg, cmtd_ctrl and cmtd_dp.
//
// Usage: items arrive on s_axis (tuser = req_type, tdata = pose and cone
// fields). A pose update is stored; a cone is rotated into the global frame
// by a 24-step CORDIC and one shared multiplier, then compared in slot order
// against the stored cones of its color up to the first duplicate, one table
// entry per cycle from the table memory. Each transaction gives one result
// on m_axis (tdata = status, map x, map y, slot, color_count).
// Sequence: a pose, or a cone that comes before any pose, goes from capture
// straight to the result register. A cone with a pose passes the CORDIC loop,
// the rotation phases and a scan of its color table through the single read
// port, which ends at a duplicate or after the stored count of its color.
// One item is in flight at a time and the next is accepted in the cycle after
// the result is registered.
// While the receiver stalls, the result waits in the output register; the
// next item may be taken and worked up to its result, then the input stalls.
// Reset clears the pose, the counts and the radius (3 m); table contents
// need no clearing. The radius is written on cfg while idle.
module cone_map_transform_dedup #(
  parameter int CAPACITY = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] pose_x, [63:32] pose_y, [79:64] pose_heading, [103:80] cone_x,
  // [127:104] cone_y, [151:128] cone_z, [152] cone_color, rest zero
  input  logic [159:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // [0] req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] status, [34:3] map x, [66:35] map y, [74:67] slot,
  // [83:75] color_count, rest zero
  output logic [87:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [20:0]  cfg_data
);
  import cmtd_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic busy, in_fire, out_free;
  logic [20:0] dup_radius;
  logic [2:0] r_status;
  logic signed [31:0] r_gx, r_gy;
  logic [7:0] r_slot;
  logic [8:0] r_cnt;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready = !busy;

  // Radius register.
  always_ff @(posedge clk) begin
    if (rst) dup_radius <= RadiusReset;
    else if (cfg_valid && cfg_ready) dup_radius <= cfg_data;
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.commit) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  assign m_axis_tdata = {4'd0, r_cnt, r_slot, r_gy, r_gx, r_status};

  cmtd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .sts(sts), .busy(busy), .cmd(cmd)
  );

  cmtd_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .dup_radius(dup_radius),
    .in_req_type(s_axis_tuser),
    .in_pose_x(s_axis_tdata[31:0]), .in_pose_y(s_axis_tdata[63:32]),
    .in_pose_heading(s_axis_tdata[79:64]),
    .in_cone_x(s_axis_tdata[103:80]), .in_cone_y(s_axis_tdata[127:104]),
    .in_cone_z(s_axis_tdata[151:128]), .in_cone_color(s_axis_tdata[152]),
    .res_status(r_status), .res_global_x(r_gx), .res_global_y(r_gy),
    .res_slot(r_slot), .res_color_count(r_cnt)
  );

  // A result only appears after a commit.
  a_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cmd.commit)) else $error("valid without commit");
  // No new item while busy.
  a_one: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_fire) else $error("accept while busy");
  // Status code stays in range.
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_NOPOSE) else $error("bad status");

endmodule

// ===== tb/cmtd_scoreboard.sv =====
// Scoreboard for the cone map block: a bit-true predictor of pose storage,
// cone transform and duplicate search, and a queue of expected results.
// Depends on cmtd_pkg for the status codes.
`timescale 1ns / 100ps

class cmtd_scoreboard;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] gx;
    logic [31:0] gy;
    logic [7:0]  slot;
    logic [8:0]  count;
  } map_result_t;

  localparam int Cap = 256;

  logic [20:0] radius;
  logic [31:0] veh_x;
  logic [31:0] veh_y;
  logic [15:0] veh_hdg;
  bit          have_pose;
  logic [31:0] tab_x[2*Cap];
  logic [31:0] tab_y[2*Cap];
  int          tab_cnt[2];
  map_result_t pending[$];
  int          n_err;
  int          n_checked;
  int          n_status[5];

  function new();
    radius = cmtd_pkg::RadiusReset;
    have_pose = 0;
    veh_x = '0;
    veh_y = '0;
    veh_hdg = '0;
    tab_cnt[0] = 0;
    tab_cnt[1] = 0;
    n_err = 0;
    n_checked = 0;
    foreach (n_status[i]) n_status[i] = 0;
  endfunction

  function void set_radius(logic [20:0] r);
    radius = r;
  endfunction

  // Rotation-mode CORDIC on the heading, with quadrant folding.
  function void heading_sincos(input logic [15:0] hdg, output longint c,
                               output longint s);
    logic [31:0] a;
    bit          flip;
    longint      x, y, z, nx, at;
    a = {hdg, 16'h0};
    flip = 0;
    x = 652032874;
    y = 0;
    if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
      a = a - 32'h8000_0000;
      flip = 1;
    end
    z = longint'(signed'(a));
    for (int i = 0; i < cmtd_pkg::CordicSteps; i++) begin
      at = longint'(cmtd_pkg::atan_lookup(i[4:0]));
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= at;
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += at;
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Works out the result of one accepted item and queues it.
  function void note_item(logic req, logic [159:0] d);
    map_result_t res;
    longint cx, cy, c, s, rx, ry, dx, dy, r;
    int col, base;
    bit dup;
    res = '0;
    col = d[152];
    base = col * Cap;
    if (!req) begin
      veh_x = d[31:0];
      veh_y = d[63:32];
      veh_hdg = d[79:64];
      have_pose = 1;
      res.status = cmtd_pkg::ST_POSE;
    end else if (!have_pose) begin
      res.status = cmtd_pkg::ST_NOPOSE;
      res.count = 9'(tab_cnt[col]);
    end else begin
      cx = longint'(signed'(d[103:80]));
      cy = longint'(signed'(d[127:104]));
      heading_sincos(veh_hdg, c, s);
      rx = (cx * c - cy * s + (longint'(1) << 29)) >>> 30;
      ry = (cx * s + cy * c + (longint'(1) << 29)) >>> 30;
      res.gx = veh_x + rx[31:0];
      res.gy = veh_y + ry[31:0];
      r = longint'(radius);
      dup = 0;
      for (int i = 0; i < tab_cnt[col]; i++) begin
        dx = longint'(signed'(res.gx)) - longint'(signed'(tab_x[base+i]));
        dy = longint'(signed'(res.gy)) - longint'(signed'(tab_y[base+i]));
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx >= r || dy >= r) continue;
        if (dx * dx + dy * dy < r * r) begin
          dup = 1;
          res.slot = i[7:0];
          break;
        end
      end
      if (dup) begin
        res.status = cmtd_pkg::ST_DUP;
      end else if (tab_cnt[col] >= Cap) begin
        res.status = cmtd_pkg::ST_FULL;
      end else begin
        res.slot = tab_cnt[col][7:0];
        tab_x[base+tab_cnt[col]] = res.gx;
        tab_y[base+tab_cnt[col]] = res.gy;
        tab_cnt[col]++;
        res.status = cmtd_pkg::ST_ADDED;
      end
      res.count = 9'(tab_cnt[col]);
    end
    pending.insert(pending.size(), res);
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %0s: got %0h, expected %0h (result %0d)", what, got, want,
             n_checked);
    n_err++;
  endfunction

  // Compares one accepted result with the oldest expectation.
  function void check_result(logic [87:0] d);
    map_result_t want;
    if (pending.size() == 0) begin
      report("unexpected result", d[31:0], 0);
      return;
    end
    want = pending.pop_front();
    if (d[2:0] != want.status) report("status", d[2:0], want.status);
    if (d[34:3] != want.gx) report("map_x", d[34:3], want.gx);
    if (d[66:35] != want.gy) report("map_y", d[66:35], want.gy);
    if (d[74:67] != want.slot) report("slot", d[74:67], want.slot);
    if (d[83:75] != want.count) report("color_count", d[83:75], want.count);
    if (d[87:84] != 4'h0) report("padding", d[87:84], 0);
    if (want.status <= cmtd_pkg::ST_NOPOSE) n_status[want.status]++;
    n_checked++;
  endfunction

endclass

// ===== tb/tb_top.sv =====
// Top of the cone map testbench: clock, reset, stream drivers, receiver
// with random stalls and one long hold-off, radius phases and the verdict.
// Depends on cmtd_pkg, cmtd_scoreboard and cone_map_transform_dedup.
`timescale 1ns / 100ps

module tb_top;
  import cmtd_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [87:0]  m_axis_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [20:0]  cfg_data;

  cmtd_scoreboard map_sb;
  bit             hold_off;
  bit             rx_enable;
  int             n_items;

  cone_map_transform_dedup dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Sends one item, holding it until the block takes it.
  task automatic send_item(logic req, logic [31:0] px, logic [31:0] py,
                           logic [15:0] hdg, logic [23:0] cx, logic [23:0] cy,
                           logic [23:0] cz, logic col);
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = req;
    s_axis_tdata = {7'd0, col, cz, cy, cx, hdg, py, px};
    do @(posedge clk); while (!s_axis_tready);
    map_sb.note_item(req, s_axis_tdata);
    n_items++;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_pose(logic [31:0] px, logic [31:0] py, logic [15:0] hdg);
    send_item(1'b0, px, py, hdg, 24'($urandom), 24'($urandom), 24'($urandom),
              1'($urandom));
  endtask

  task automatic send_cone(logic [23:0] cx, logic [23:0] cy, logic col);
    send_item(1'b1, $urandom, $urandom, 16'($urandom), cx, cy, 24'($urandom), col);
  endtask

  // Waits for all results, then lets the block settle before a write.
  task automatic drain();
    int guard;
    guard = 0;
    while (map_sb.pending.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (400) @(negedge clk);
  endtask

  task automatic write_radius(logic [20:0] r);
    cfg_valid <= 1'b1;
    cfg_data <= r;
    do @(posedge clk); while (!cfg_ready);
    map_sb.set_radius(r);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random cone near a small set of points, so duplicates are frequent.
  task automatic random_cone(int spread);
    logic [23:0] cx, cy;
    if ($urandom_range(0, 9) == 0) begin
      cx = 24'($urandom);
      cy = 24'($urandom);
    end else begin
      cx = 24'($urandom_range(0, 7) * 24'h40000 + $urandom_range(0, spread));
      cy = 24'($urandom_range(0, 7) * 24'h40000 + $urandom_range(0, spread));
    end
    send_cone(cx, cy, 1'($urandom_range(0, 1)));
  endtask

  // Receiver: random stalls, plus the long hold-off when requested.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off || !rx_enable) begin
        m_axis_tready <= 1'b0;
      end else begin
        stall = $urandom_range(0, 3);
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
          @(negedge clk);
        end
        m_axis_tready <= 1'b1;
        do @(posedge clk); while (!m_axis_tvalid);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) map_sb.check_result(m_axis_tdata);
  end

  // Run limit.
  initial begin
    #50ms;
    $display("Timeout with %0d results outstanding", map_sb.pending.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [20:0] radii[5];
    map_sb = new();
    hold_off = 0;
    rx_enable = 1;
    n_items = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: cones before any pose, extreme poses and cone coordinates.
    send_cone(24'h000000, 24'h000000, 1'b0);
    send_cone(24'hFFFFFF, 24'h7FFFFF, 1'b1);
    send_pose(32'h0, 32'h0, 16'h0000);
    send_cone(24'h010000, 24'h020000, 1'b0);
    send_cone(24'h010000, 24'h020000, 1'b0);
    send_cone(24'h7FFFFF, 24'h800000, 1'b1);
    send_cone(24'h800000, 24'h800000, 1'b1);
    send_pose(32'h7FFFFFFF, 32'h80000000, 16'h4000);
    send_cone(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_pose(32'h80000000, 32'h7FFFFFFF, 16'h8000);
    send_cone(24'h800000, 24'h7FFFFF, 1'b1);
    send_pose(32'hFFFFFFFF, 32'h00000001, 16'hFFFF);
    send_cone(24'h123456, 24'hABCDEF, 1'b0);
    send_pose(32'h00010000, 32'hFFFF0000, 16'hC000);
    send_cone(24'h030000, 24'hFD0000, 1'b1);
    send_pose(32'h0, 32'h0, 16'h2000);
    send_cone(24'h000000, 24'h000000, 1'b0);
    drain();

    // Random phases across radius settings, extremes among them.
    radii[0] = 21'd0;
    radii[1] = 21'h1FFFFF;
    radii[2] = 21'd1048576;
    radii[3] = 21'd196608;
    radii[4] = 21'd1;
    for (int ph = 0; ph < 5; ph++) begin
      write_radius(radii[ph]);
      for (int k = 0; k < 360; k++) begin
        if (ph == 2 && k == 100) begin
          hold_off = 1;
          fork
            begin
              repeat (300) @(negedge clk);
              hold_off = 0;
            end
          join_none
        end
        if ($urandom_range(0, 15) == 0) begin
          send_pose($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h40000),
                    $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h40000),
                    16'($urandom));
        end else begin
          random_cone(ph == 4 ? 3 : 32'h1FFFF);
        end
      end
      drain();
    end

    $display("Sent %0d items; results: %0d pose, %0d added, %0d duplicate,",
             n_items, map_sb.n_status[ST_POSE], map_sb.n_status[ST_ADDED],
             map_sb.n_status[ST_DUP]);
    $display("  %0d table full, %0d no pose, over five radius settings.",
             map_sb.n_status[ST_FULL], map_sb.n_status[ST_NOPOSE]);
    if (map_sb.n_err == 0 && map_sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
